// ----- hw/rtl/fdp_pkg.sv -----
// ----------------------------------------------------------------------------
// fdp_pkg
// Types and constants shared by the frame deadline pacer files.
// ----------------------------------------------------------------------------
package fdp_pkg;

   localparam int OPCODE_W    = 1;
   localparam int NOW_W       = 63;
   localparam int DEADLINE_W  = 64;
   localparam int ACTION_W    = 3;
   localparam int COUNT_W     = 5;
   localparam int INTERVAL_W  = 32;
   localparam int LAG_W       = 4;
   localparam int SPAN_W      = INTERVAL_W + LAG_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // default frame period: 1.001/60 s in ns
   localparam longint NS_PER_SEC    = 1000000000;
   localparam longint NTSC_NUM      = 1001;
   localparam longint NTSC_DEN      = 60000;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET =
      INTERVAL_W'(NS_PER_SEC * NTSC_NUM / NTSC_DEN);
   localparam logic [LAG_W-1:0] MAX_LAG_RESET = LAG_W'(4);
   localparam logic ENABLE_RESET = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LAG  = 2'd2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK = 1'b0,
      OP_WAKE = 1'b1
   } opcode_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_DISABLED      = 3'd0,
      ACT_ARMED         = 3'd1,
      ACT_STALL         = 3'd2,
      ACT_LATE          = 3'd3,
      ACT_WAIT          = 3'd4,
      ACT_WAKE_OK       = 3'd5,
      ACT_WAKE_REANCHOR = 3'd6,
      ACT_STRAY_WAKE    = 3'd7
   } action_type;

   typedef struct packed {
      logic subtract;
      logic saturate;
   } alu_ctrl_type;

   typedef struct packed {
      logic [DEADLINE_W-1:0] value;
      logic                  carry;
   } alu_result_type;

endpackage

// ----- hw/rtl/fdp_if.sv -----
// ----------------------------------------------------------------------------
// fdp channel interfaces
// Request, response and register-write channels of the frame deadline pacer.
// ----------------------------------------------------------------------------
interface fdp_req_if;
   logic                         valid;
   logic                         ready;
   logic [fdp_pkg::OPCODE_W-1:0] opcode;
   logic [fdp_pkg::NOW_W-1:0]    now_time;

   modport source (output valid, output opcode, output now_time, input ready);
   modport sink   (input valid, input opcode, input now_time, output ready);
endinterface

interface fdp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fdp_pkg::ACTION_W-1:0]   action;
   logic [fdp_pkg::DEADLINE_W-1:0] deadline_out;
   logic [fdp_pkg::COUNT_W-1:0]    intervals_advanced;

   modport source (output valid, output action, output deadline_out,
                   output intervals_advanced, input ready);
   modport sink   (input valid, input action, input deadline_out,
                   input intervals_advanced, output ready);
endinterface

interface fdp_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fdp_pkg::CSR_INDEX_W-1:0] index;
   logic [fdp_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/fdp_alu.sv -----
// ----------------------------------------------------------------------------
// fdp_alu
// Shared 64-bit add/subtract unit with carry out and optional saturation.
// ----------------------------------------------------------------------------
module fdp_alu (
   input  logic [fdp_pkg::DEADLINE_W-1:0] operand_a,
   input  logic [fdp_pkg::DEADLINE_W-1:0] operand_b,
   input  fdp_pkg::alu_ctrl_type          ctrl,
   output fdp_pkg::alu_result_type        result
);

   localparam int DW = fdp_pkg::DEADLINE_W;

   logic [DW-1:0] b_eff;
   logic [DW:0]   sum;

   // subtract as a + ~b + 1; carry set means no borrow
   assign b_eff = ctrl.subtract ? ~operand_b : operand_b;
   assign sum   = {1'b0, operand_a} + {1'b0, b_eff} + {{DW{1'b0}}, ctrl.subtract};

   assign result.carry = sum[DW];
   assign result.value = (ctrl.saturate && !ctrl.subtract && sum[DW]) ?
                         {DW{1'b1}} : sum[DW-1:0];

endmodule

// ----- hw/rtl/frame_deadline_pacer_unit.sv -----
// ----------------------------------------------------------------------------
// frame_deadline_pacer_unit
// Absolute-deadline frame pacer driven by tick and wake items.
// ----------------------------------------------------------------------------
// Steps: each item passes the difference and compare states; an item that
//   arms, re-anchors or advances the schedule by one wait then takes an
//   add state, and a late tick that advances n intervals (n up to 16) takes
//   a step and a check state per interval, as the shared adder adds, then compares.
// Throughput: one item at a time; the next item is taken in the cycle after
//   the result is taken. Reset: schedule unarmed, no wait pending, registers
//   at their defaults.
module frame_deadline_pacer_unit #(
   parameter int TIME_BITS = 63
) (
   input logic        clock,
   input logic        reset,
   fdp_req_if.sink    req_if,
   fdp_rsp_if.source  rsp_if,
   fdp_csr_if.sink    csr_if
);

   localparam int DW = fdp_pkg::DEADLINE_W;
   localparam int IW = fdp_pkg::INTERVAL_W;
   localparam int SW = fdp_pkg::SPAN_W;
   localparam int CW = fdp_pkg::COUNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIFF,
      S_CMP,
      S_ADD_NOW,
      S_WAIT_ADD,
      S_LATE,
      S_LCHK,
      S_OUT
   } state_type;

   state_type                   state_ff, state_in;
   logic                        enable_ff, enable_in;
   logic [IW-1:0]               interval_ff, interval_in;
   logic [fdp_pkg::LAG_W-1:0]   max_lag_ff, max_lag_in;

   fdp_pkg::opcode_type         op_ff, op_in;
   logic [TIME_BITS-1:0]        now_ff, now_in;
   logic [IW-1:0]               iv_ff, iv_in;
   logic [SW-1:0]               span_ff, span_in;
   logic [DW-1:0]               diff_ff, diff_in;
   logic                        ge_ff, ge_in;

   logic [DW-1:0]               nd_ff, nd_in;
   logic                        armed_ff, armed_in;
   logic                        wp_ff, wp_in;

   fdp_pkg::action_type         action_ff, action_in;
   logic [DW-1:0]               dl_ff, dl_in;
   logic [CW-1:0]               cnt_ff, cnt_in;

   logic [IW-1:0]               iv_eff;
   logic [DW-1:0]               now_ext;
   logic [DW-1:0]               alu_a, alu_b;
   fdp_pkg::alu_ctrl_type       alu_ctrl;
   fdp_pkg::alu_result_type     alu_res;
   logic                        lag;
   logic                        req_take;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_take     = req_if.valid && req_if.ready;

   assign rsp_if.valid              = (state_ff == S_OUT);
   assign rsp_if.action             = action_ff;
   assign rsp_if.deadline_out       = dl_ff;
   assign rsp_if.intervals_advanced = cnt_ff;

   // a zero interval counts as one time unit
   assign iv_eff  = (interval_ff == '0) ? IW'(1) : interval_ff;
   assign now_ext = {{(DW-TIME_BITS){1'b0}}, now_ff};

   // lag beyond span: now > deadline and (now - deadline) > span
   assign lag = ge_ff && (diff_ff != '0) && !alu_res.carry;

   // operand selection for the shared adder
   always_comb begin
      alu_a    = now_ext;
      alu_b    = nd_ff;
      alu_ctrl = '{subtract: 1'b1, saturate: 1'b0};
      unique case (state_ff)
         S_CMP: begin
            alu_a = {{(DW-SW){1'b0}}, span_ff};
            alu_b = diff_ff;
         end
         S_ADD_NOW: begin
            alu_b    = {{(DW-IW){1'b0}}, iv_ff};
            alu_ctrl = '{subtract: 1'b0, saturate: 1'b0};
         end
         S_WAIT_ADD, S_LATE: begin
            alu_a    = nd_ff;
            alu_b    = {{(DW-IW){1'b0}}, iv_ff};
            alu_ctrl = '{subtract: 1'b0, saturate: 1'b1};
         end
         S_IDLE, S_DIFF, S_LCHK, S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   fdp_alu u_alu (
      .operand_a (alu_a),
      .operand_b (alu_b),
      .ctrl      (alu_ctrl),
      .result    (alu_res)
   );

   always_comb begin
      state_in    = state_ff;
      enable_in   = enable_ff;
      interval_in = interval_ff;
      max_lag_in  = max_lag_ff;
      op_in       = op_ff;
      now_in      = now_ff;
      iv_in       = iv_ff;
      span_in     = span_ff;
      diff_in     = diff_ff;
      ge_in       = ge_ff;
      nd_in       = nd_ff;
      armed_in    = armed_ff;
      wp_in       = wp_ff;
      action_in   = action_ff;
      dl_in       = dl_ff;
      cnt_in      = cnt_ff;

      if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            fdp_pkg::CSR_ENABLE:   enable_in   = csr_if.data[0];
            fdp_pkg::CSR_INTERVAL: interval_in = csr_if.data[IW-1:0];
            fdp_pkg::CSR_MAX_LAG:  max_lag_in  = csr_if.data[fdp_pkg::LAG_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = fdp_pkg::opcode_type'(req_if.opcode);
               now_in   = req_if.now_time[TIME_BITS-1:0];
               iv_in    = iv_eff;
               span_in  = SW'(iv_eff) * SW'(max_lag_ff);
               cnt_in   = '0;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in  = alu_res.value;
            ge_in    = alu_res.carry;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (op_ff == fdp_pkg::OP_TICK) begin
               wp_in = 1'b0;
               priority if (!enable_ff) begin
                  armed_in  = 1'b0;
                  nd_in     = '0;
                  dl_in     = '0;
                  action_in = fdp_pkg::ACT_DISABLED;
                  state_in  = S_OUT;
               end else if (!armed_ff) begin
                  armed_in  = 1'b1;
                  action_in = fdp_pkg::ACT_ARMED;
                  state_in  = S_ADD_NOW;
               end else if (lag) begin
                  action_in = fdp_pkg::ACT_STALL;
                  state_in  = S_ADD_NOW;
               end else if (ge_ff) begin
                  action_in = fdp_pkg::ACT_LATE;
                  state_in  = S_LATE;
               end else begin
                  dl_in     = nd_ff;
                  wp_in     = 1'b1;
                  action_in = fdp_pkg::ACT_WAIT;
                  state_in  = S_WAIT_ADD;
               end
            end else begin
               priority if (!wp_ff) begin
                  dl_in     = nd_ff;
                  action_in = fdp_pkg::ACT_STRAY_WAKE;
                  state_in  = S_OUT;
               end else if (lag) begin
                  wp_in     = 1'b0;
                  action_in = fdp_pkg::ACT_WAKE_REANCHOR;
                  state_in  = S_ADD_NOW;
               end else begin
                  wp_in     = 1'b0;
                  dl_in     = nd_ff;
                  action_in = fdp_pkg::ACT_WAKE_OK;
                  state_in  = S_OUT;
               end
            end
         end
         S_ADD_NOW: begin
            nd_in    = alu_res.value;
            dl_in    = alu_res.value;
            state_in = S_OUT;
         end
         S_WAIT_ADD: begin
            nd_in    = alu_res.value;
            state_in = S_OUT;
         end
         S_LATE: begin
            nd_in    = alu_res.value;
            cnt_in   = cnt_ff + CW'(1);
            state_in = S_LCHK;
         end
         S_LCHK: begin
            // keep stepping while the deadline is not yet in the future
            if (alu_res.carry) begin
               state_in = S_LATE;
            end else begin
               dl_in    = nd_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         enable_ff   <= fdp_pkg::ENABLE_RESET;
         interval_ff <= fdp_pkg::INTERVAL_RESET;
         max_lag_ff  <= fdp_pkg::MAX_LAG_RESET;
         nd_ff       <= '0;
         armed_ff    <= 1'b0;
         wp_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         enable_ff   <= enable_in;
         interval_ff <= interval_in;
         max_lag_ff  <= max_lag_in;
         nd_ff       <= nd_in;
         armed_ff    <= armed_in;
         wp_ff       <= wp_in;
      end
      op_ff     <= op_in;
      now_ff    <= now_in;
      iv_ff     <= iv_in;
      span_ff   <= span_in;
      diff_ff   <= diff_in;
      ge_ff     <= ge_in;
      action_ff <= action_in;
      dl_ff     <= dl_in;
      cnt_ff    <= cnt_in;
   end

   // a pending wait only exists on an armed schedule
   a_wait_needs_armed: assert property (@(posedge clock) disable iff (reset)
      wp_ff |-> armed_ff)
      else $error("wait pending on unarmed schedule");

   // no new item while a result is held
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_if.ready)
      else $error("request taken while busy");

   a_rsp_excludes_req: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !req_if.ready)
      else $error("ready while a result is held");

   // interval count only on late advance, and then within 1..16
   a_count_only_late: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (cnt_ff != '0) |-> action_ff == fdp_pkg::ACT_LATE)
      else $error("interval count on non-late result");

   a_late_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (action_ff == fdp_pkg::ACT_LATE) |->
         (cnt_ff != '0) && (cnt_ff <= CW'(16)))
      else $error("late advance count out of range");

endmodule

// ----- sim/frame_deadline_pacer_unit_test.sv -----
// ----------------------------------------------------------------------------
// frame_deadline_pacer_unit_test
// Self-checking bench for the frame deadline pacer. Tick and wake items are
// placed around the predicted deadline, so arming, waits, late catch-up,
// stall and drift re-anchoring and stray wakes are all reached. Each result
// is compared with an in-bench schedule predictor. Both channels idle at
// random, and register settings change between phases while the block idles.
// ----------------------------------------------------------------------------
module frame_deadline_pacer_unit_test;

   localparam logic [fdp_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [fdp_pkg::DEADLINE_W-1:0]  NOW_MAX    =
      {1'b0, {fdp_pkg::NOW_W{1'b1}}};

   typedef enum {
      PLACE_EARLY, PLACE_ON_TIME, PLACE_LATE, PLACE_LAG_EDGE, PLACE_STALL, PLACE_ANY
   } time_place_type;

   typedef struct {
      fdp_pkg::action_type            action;
      logic [fdp_pkg::DEADLINE_W-1:0] deadline;
      logic [fdp_pkg::COUNT_W-1:0]    steps;
   } pace_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fdp_req_if req_bus ();
   fdp_rsp_if rsp_bus ();
   fdp_csr_if csr_bus ();

   frame_deadline_pacer_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #1 clock = ~clock;

   // predictor copy of the registers and the schedule
   logic                           pace_enable;
   logic [fdp_pkg::INTERVAL_W-1:0] pace_interval;
   logic [fdp_pkg::LAG_W-1:0]      pace_max_lag;
   logic [fdp_pkg::DEADLINE_W-1:0] sched_deadline;
   logic                           sched_armed;
   logic                           pace_wake_owed;

   pace_result_type pace_expect_q[$];
   int              fail_count      = 0;
   bit              send_idle_on    = 1'b1;
   bit              rsp_idle_on     = 1'b1;
   int              rsp_hold_cycles = 0;

   function automatic logic [fdp_pkg::DEADLINE_W-1:0] eff_interval();
      return (pace_interval == '0) ? 64'd1 : {32'd0, pace_interval};
   endfunction

   function automatic pace_result_type pace_predict(fdp_pkg::opcode_type op,
                                                    logic [fdp_pkg::NOW_W-1:0] now_in);
      pace_result_type                r;
      logic [fdp_pkg::DEADLINE_W-1:0] iv, span, now64, steps;
      logic [fdp_pkg::DEADLINE_W:0]   sum;
      logic                           lag_hit;
      iv      = eff_interval();
      span    = iv * pace_max_lag;
      now64   = {1'b0, now_in};
      lag_hit = (now64 > sched_deadline) && ((now64 - sched_deadline) > span);
      r.steps = '0;
      if (op == fdp_pkg::OP_TICK) begin
         pace_wake_owed = 1'b0;
         if (!pace_enable) begin
            sched_armed    = 1'b0;
            sched_deadline = '0;
            r.action       = fdp_pkg::ACT_DISABLED;
            r.deadline     = '0;
         end else if (!sched_armed) begin
            sched_armed    = 1'b1;
            sched_deadline = now64 + iv;
            r.action       = fdp_pkg::ACT_ARMED;
            r.deadline     = sched_deadline;
         end else if (lag_hit) begin
            sched_deadline = now64 + iv;
            r.action       = fdp_pkg::ACT_STALL;
            r.deadline     = sched_deadline;
         end else if (now64 >= sched_deadline) begin
            steps          = (now64 - sched_deadline) / iv + 64'd1;
            sched_deadline = sched_deadline + steps * iv;
            r.action       = fdp_pkg::ACT_LATE;
            r.deadline     = sched_deadline;
            r.steps        = steps[fdp_pkg::COUNT_W-1:0];
         end else begin
            r.deadline     = sched_deadline;
            sum            = {1'b0, sched_deadline} + {1'b0, iv};
            sched_deadline = sum[fdp_pkg::DEADLINE_W] ? '1 : sum[fdp_pkg::DEADLINE_W-1:0];
            pace_wake_owed = 1'b1;
            r.action       = fdp_pkg::ACT_WAIT;
         end
      end else begin
         if (!pace_wake_owed) begin
            r.action = fdp_pkg::ACT_STRAY_WAKE;
         end else begin
            pace_wake_owed = 1'b0;
            if (lag_hit) begin
               sched_deadline = now64 + iv;
               r.action       = fdp_pkg::ACT_WAKE_REANCHOR;
            end else begin
               r.action = fdp_pkg::ACT_WAKE_OK;
            end
         end
         r.deadline = sched_deadline;
      end
      return r;
   endfunction

   function automatic logic [fdp_pkg::NOW_W-1:0] to_now(logic [fdp_pkg::DEADLINE_W-1:0] t);
      return (t > NOW_MAX) ? NOW_MAX[fdp_pkg::NOW_W-1:0] : t[fdp_pkg::NOW_W-1:0];
   endfunction

   function automatic time_place_type draw_place();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return PLACE_EARLY;
      if (r < 60) return PLACE_ON_TIME;
      if (r < 78) return PLACE_LATE;
      if (r < 85) return PLACE_LAG_EDGE;
      if (r < 92) return PLACE_STALL;
      return PLACE_ANY;
   endfunction

   // time stamp placed relative to the predicted deadline
   function automatic logic [fdp_pkg::NOW_W-1:0] place_time(time_place_type place);
      logic [fdp_pkg::DEADLINE_W-1:0] iv, span, off, t;
      iv   = eff_interval();
      span = iv * pace_max_lag;
      off  = {32'd0, $urandom} % iv;
      case (place)
         PLACE_EARLY:    t = (sched_deadline > off) ? sched_deadline - off - 1 : '0;
         PLACE_ON_TIME:  t = $urandom_range(0, 1) ? sched_deadline : sched_deadline + off;
         PLACE_LATE:     t = sched_deadline + iv * $urandom_range(0, pace_max_lag) + off;
         PLACE_LAG_EDGE: t = sched_deadline + span + $urandom_range(0, 1);
         PLACE_STALL:    t = sched_deadline + span + 1 + ({32'd0, $urandom} << $urandom_range(0, 8));
         default:        t = {$urandom, $urandom};
      endcase
      return to_now(t);
   endfunction

   task automatic send_item(fdp_pkg::opcode_type op, logic [fdp_pkg::NOW_W-1:0] now_in);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op;
      req_bus.now_time <= now_in;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pace_expect_q.push_back(pace_predict(op, now_in));
   endtask

   task automatic csr_write(logic [fdp_pkg::CSR_INDEX_W-1:0] idx,
                            logic [fdp_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         fdp_pkg::CSR_ENABLE:   pace_enable   = value[0];
         fdp_pkg::CSR_INTERVAL: pace_interval = value;
         fdp_pkg::CSR_MAX_LAG:  pace_max_lag  = value[fdp_pkg::LAG_W-1:0];
         default:               ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // sender stops until every outstanding result is back
   task automatic wait_results_in();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pace_expect_q.size() != 0) @(posedge clock);
   endtask

   // mostly tick/wake pairs; the rest are dropped waits and stray wakes
   task automatic pace_one_random();
      int pick;
      pick = $urandom_range(0, 99);
      if (pace_wake_owed && pick < 85)
         send_item(fdp_pkg::OP_WAKE, place_time(draw_place()));
      else if (pick >= 95)
         send_item(fdp_pkg::OP_WAKE, place_time(PLACE_ANY));
      else
         send_item(fdp_pkg::OP_TICK, place_time(draw_place()));
   endtask

   task automatic test_reset_defaults();
      send_item(fdp_pkg::OP_TICK, 63'd1000);
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_EARLY));
      send_item(fdp_pkg::OP_WAKE, place_time(PLACE_ON_TIME));
      send_item(fdp_pkg::OP_WAKE, place_time(PLACE_ON_TIME));
      send_item(fdp_pkg::OP_TICK, to_now(sched_deadline));
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_LATE));
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_STALL));
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_EARLY));
      // second early tick drops the pending wait
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_EARLY));
      send_item(fdp_pkg::OP_WAKE, place_time(PLACE_STALL));
      wait_results_in();
   endtask

   task automatic test_special_cases();
      logic [fdp_pkg::DEADLINE_W-1:0] span;
      // zero interval acts as one unit; zero lag re-anchors on any lateness
      csr_write(fdp_pkg::CSR_INTERVAL, '0);
      csr_write(fdp_pkg::CSR_MAX_LAG, ($urandom & ~32'hF));
      send_item(fdp_pkg::OP_TICK, to_now(sched_deadline));
      send_item(fdp_pkg::OP_TICK, to_now(sched_deadline + 1));
      wait_results_in();
      csr_write(fdp_pkg::CSR_INTERVAL, 32'hFFFF_FFFF);
      csr_write(fdp_pkg::CSR_MAX_LAG, 32'hFFFF_FFFF);
      span = eff_interval() * pace_max_lag;
      // right at the lag limit: widest catch-up
      send_item(fdp_pkg::OP_TICK, to_now(sched_deadline + span));
      send_item(fdp_pkg::OP_TICK, NOW_MAX[fdp_pkg::NOW_W-1:0]);
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_EARLY));
      send_item(fdp_pkg::OP_TICK, '0);
      send_item(fdp_pkg::OP_WAKE, '0);
      wait_results_in();
   endtask

   task automatic test_disable();
      csr_write(fdp_pkg::CSR_ENABLE, $urandom & ~32'h1);
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_ANY));
      send_item(fdp_pkg::OP_WAKE, place_time(PLACE_ANY));
      wait_results_in();
      csr_write(CSR_UNUSED, $urandom);
      csr_write(fdp_pkg::CSR_ENABLE, $urandom | 32'h1);
      csr_write(fdp_pkg::CSR_INTERVAL, fdp_pkg::INTERVAL_RESET);
      csr_write(fdp_pkg::CSR_MAX_LAG, 32'(fdp_pkg::MAX_LAG_RESET));
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_ANY));
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_EARLY));
      wait_results_in();
      // pending wait still completes after disabling
      csr_write(fdp_pkg::CSR_ENABLE, '0);
      send_item(fdp_pkg::OP_WAKE, place_time(PLACE_ON_TIME));
      send_item(fdp_pkg::OP_TICK, place_time(PLACE_ANY));
      wait_results_in();
      csr_write(fdp_pkg::CSR_ENABLE, 32'd1);
   endtask

   task automatic test_backpressure();
      rsp_hold_cycles = 80;
      send_idle_on    = 1'b0;
      repeat (12) pace_one_random();
      wait_results_in();
      send_idle_on    = 1'b1;
   endtask

   task automatic test_random_phases();
      logic [fdp_pkg::INTERVAL_W-1:0] interval_val;
      logic [fdp_pkg::LAG_W-1:0]      lag_val;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin interval_val = 32'd1;          lag_val = 4'd0;          end
            1: begin interval_val = 32'hFFFF_FFFF;  lag_val = 4'hF;          end
            2: begin
               interval_val = fdp_pkg::INTERVAL_RESET;
               lag_val      = fdp_pkg::MAX_LAG_RESET;
            end
            3: begin interval_val = '0;             lag_val = 4'hF;          end
            default: begin
               case ($urandom_range(0, 2))
                  0:       interval_val = $urandom_range(1, 64);
                  1:       interval_val = $urandom_range(65, 100000);
                  default: interval_val = $urandom;
               endcase
               lag_val = 4'($urandom_range(0, 15));
            end
         endcase
         wait_results_in();
         csr_write(fdp_pkg::CSR_INTERVAL, interval_val);
         csr_write(fdp_pkg::CSR_MAX_LAG, ($urandom & ~32'hF) | 32'(lag_val));
         csr_write(fdp_pkg::CSR_ENABLE, ($urandom & ~32'h1) | 32'(phase != 6));
         if (phase % 4 == 3) csr_write(CSR_UNUSED, $urandom);
         send_idle_on = (phase % 3 != 1);
         rsp_idle_on  = (phase % 3 != 2);
         repeat (48) pace_one_random();
      end
      wait_results_in();
   endtask

   // receiver: random stalls per result, plus an occasional long hold-off
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, 5) : 0;
         gap += rsp_hold_cycles;
         rsp_hold_cycles = 0;
         @(negedge clock);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      pace_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pace_expect_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: action %0d deadline %h steps %0d",
                        rsp_bus.action, rsp_bus.deadline_out, rsp_bus.intervals_advanced);
         end else begin
            want = pace_expect_q.pop_front();
            if (rsp_bus.action !== want.action || rsp_bus.deadline_out !== want.deadline ||
                rsp_bus.intervals_advanced !== want.steps) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected action %0d deadline %h steps %0d, got %0d %h %0d",
                           want.action, want.deadline, want.steps, rsp_bus.action,
                           rsp_bus.deadline_out, rsp_bus.intervals_advanced);
            end
         end
      end
   end

   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.opcode   = fdp_pkg::OP_TICK;
      req_bus.now_time = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = fdp_pkg::CSR_ENABLE;
      csr_bus.data     = '0;
      pace_enable      = fdp_pkg::ENABLE_RESET;
      pace_interval    = fdp_pkg::INTERVAL_RESET;
      pace_max_lag     = fdp_pkg::MAX_LAG_RESET;
      sched_deadline   = '0;
      sched_armed      = 1'b0;
      pace_wake_owed   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_special_cases();
      test_disable();
      test_backpressure();
      test_random_phases();

      // leave room for the longest catch-up to drain
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pace_expect_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
